### sv/target_point_transform_smoother_macros.svh
// Assertion helpers for the RTL file that carries checks.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef TARGET_POINT_TRANSFORM_SMOOTHER_MACROS_SVH
`define TARGET_POINT_TRANSFORM_SMOOTHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPTS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tpts_pkg.sv
`default_nettype none

package tpts_pkg;

   // Datapath widths of the shared multiply-accumulate unit.
   localparam int OpaWidth  = 33;
   localparam int OpbWidth  = 18;
   localparam int ProdWidth = OpaWidth + OpbWidth;
   localparam int AccWidth  = 52;
   localparam int FracBits  = 16;

   // Item kinds carried on req_tuser.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_ALPHA = 1'd0;
   localparam logic [0:0] CSR_DELTA = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XFORM,
      ST_XLAST,
      ST_SMOOTH,
      ST_SLAST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctrl_type;

   // Fixed camera-to-body rotation part, Q2.16.
   function automatic logic signed [OpbWidth-1:0] xf_coef(input logic [1:0] row,
                                                         input logic [1:0] col);
      logic signed [OpbWidth-1:0] c;
      case ({row, col})
         4'b00_10: c = 18'sd65536;
         4'b01_00: c = -18'sd65536;
         4'b10_01: c = -18'sd65536;
         default:  c = '0;
      endcase
      return c;
   endfunction

   // Translation part, signed with 16 fraction bits (Q16.16 scale), added as a Q20.32 accumulator term.
   function automatic logic signed [12:0] xf_offset(input logic [1:0] row);
      logic signed [12:0] o;
      case (row)
         2'd1:    o = 13'sd2294;
         2'd2:    o = -13'sd131;
         default: o = '0;
      endcase
      return o;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/tpts_mac.sv
`default_nettype none

// Shared signed multiply-accumulate unit with round-half-up to Q16.16 and
// saturation on the accumulator output.
module tpts_mac (
   input  wire                                   clock,
   input  tpts_pkg::mac_ctrl_type                ctrl,
   input  wire  signed [tpts_pkg::OpaWidth-1:0]  op_a,
   input  wire  signed [tpts_pkg::OpbWidth-1:0]  op_b,
   input  wire  signed [tpts_pkg::AccWidth-1:0]  acc_init,
   output logic signed [31:0]                    result
);

   localparam logic signed [tpts_pkg::AccWidth-1:0] RoundHalf =
      tpts_pkg::AccWidth'(1) <<< (tpts_pkg::FracBits - 1);

   logic signed [tpts_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic signed [tpts_pkg::AccWidth-1:0]  acc_ff, acc_in;
   logic signed [tpts_pkg::AccWidth-1:0]  acc_rnd;
   logic signed [tpts_pkg::AccWidth-1:0]  acc_shift;

   always_comb begin
      prod_in = ctrl.mul_en ? op_a * op_b : prod_ff;
      if (ctrl.acc_load) begin
         acc_in = acc_init;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + tpts_pkg::AccWidth'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Floor of (acc + 2^15) / 2^16 is an arithmetic shift.
   assign acc_rnd   = acc_ff + RoundHalf;
   assign acc_shift = acc_rnd >>> tpts_pkg::FracBits;
   assign result    = tpts_pkg::sat32(signed'(acc_shift[35:0]));

endmodule

`default_nettype wire

### sv/tpts_track.sv
`default_nettype none

// Holds the target pixel position and colour and flags a new target when
// either coordinate moves by more than the configured distance.
module tpts_track (
   input  wire         clock,
   input  wire         reset,
   input  wire         pix_en,
   input  wire  [11:0] pix_col,
   input  wire  [11:0] pix_row,
   input  wire  [23:0] colour_in,
   input  wire  [11:0] delta,
   output logic [23:0] colour,
   output logic        new_target
);

   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic [23:0] colour_ff, colour_in_q;
   logic [11:0] col_diff, row_diff;

   assign col_diff   = (pix_col > col_ff) ? pix_col - col_ff : col_ff - pix_col;
   assign row_diff   = (pix_row > row_ff) ? pix_row - row_ff : row_ff - pix_row;
   assign new_target = pix_en && ((col_diff > delta) || (row_diff > delta));

   always_comb begin
      col_in      = new_target ? pix_col : col_ff;
      row_in      = new_target ? pix_row : row_ff;
      colour_in_q = pix_en ? colour_in : colour_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         colour_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         colour_ff <= colour_in_q;
      end
   end

   assign colour = colour_ff;

endmodule

`default_nettype wire

### sv/target_point_transform_smoother.sv
// Target point transform smoother.
// Input beats arrive on the req_ stream. req_tuser selects the kind of beat:
// a pixel beat updates the stored target colour and, when the column or row
// moves by more than the new-target distance, the target position, and arms
// a filter reload. It is taken without leaving the idle state and gives no
// result beat. A point beat is mapped through the fixed affine transform
// and smoothed with alpha (or taken as is on an armed reload); it gives one
// result beat on the rsp_ stream with x, -y, -z and the stored colour. The
// transform and the smoothing run on one shared multiply-accumulate unit:
// the transform steps (ST_XFORM), a step to finish them (ST_XLAST), the
// smoothing steps (ST_SMOOTH, ST_SLAST, skipped on a reload) and ST_DONE,
// which loads the output register; req_tready returns in the same cycle as
// rsp_tvalid rises. The csr_ port writes alpha (index 0) and the new-target
// distance (index 1); the user must do so only while the block is idle, as
// the block does not enforce it. A result waits in an output register; the
// block still takes new beats while rsp_tready is low, and a finished point
// holds until the register frees. Synchronous reset restores alpha = 0.2,
// distance = 5, clears the target and colour and arms a reload.
`default_nettype none
`include "target_point_transform_smoother_macros.svh"

module target_point_transform_smoother (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // pix_col, pix_row, red_in, green_in, blue_in, pos_x_in, pos_y_in, pos_z_in
   input  wire  [143:0] req_tdata,
   // operation
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // out_x, out_y, out_z, red_out, green_out, blue_out
   output logic [119:0] rsp_tdata,
   input  wire          csr_we,
   input  wire  [0:0]   csr_index,
   input  wire  [15:0]  csr_wdata
);

   tpts_pkg::state_type state_ff, state_in;
   logic [1:0]          coord_ff, coord_in;
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          prev_coord;
   logic [15:0]         alpha_ff, alpha_in;
   logic [11:0]         delta_ff, delta_in;
   logic                armed_ff, armed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [119:0]        rsp_data_ff, rsp_data_in;

   // Captured point and the transformed and filtered coordinates.
   logic signed [31:0] pos_ff  [3];
   logic signed [31:0] pos_in  [3];
   logic signed [31:0] xf_ff   [3];
   logic signed [31:0] xf_in   [3];
   logic signed [31:0] filt_ff [3];
   logic signed [31:0] filt_in [3];

   tpts_pkg::mac_ctrl_type                    mac_ctrl;
   logic signed [tpts_pkg::OpaWidth-1:0]      mac_op_a;
   logic signed [tpts_pkg::OpbWidth-1:0]      mac_op_b;
   logic signed [tpts_pkg::AccWidth-1:0]      mac_init;
   logic signed [31:0]                        mac_result;
   logic signed [31:0]                        pos_sel;

   logic        req_accept;
   logic        pix_en;
   logic        new_target;
   logic [23:0] colour;
   logic        rsp_load;
   logic signed [31:0] neg_y, neg_z;

   assign req_tready = (state_ff == tpts_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign pix_en     = req_accept && (req_tuser[0] == tpts_pkg::OP_PIXEL);
   assign prev_coord = coord_ff - 2'd1;

   tpts_track u_track (
      .clock      (clock),
      .reset      (reset),
      .pix_en     (pix_en),
      .pix_col    (req_tdata[11:0]),
      .pix_row    (req_tdata[23:12]),
      .colour_in  ({req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]}),
      .delta      (delta_ff),
      .colour     (colour),
      .new_target (new_target)
   );

   tpts_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_a     (mac_op_a),
      .op_b     (mac_op_b),
      .acc_init (mac_init),
      .result   (mac_result)
   );

   // The transform walks the three input coordinates by phase.
   always_comb begin
      case (phase_ff)
         2'd0:    pos_sel = pos_ff[0];
         2'd1:    pos_sel = pos_ff[1];
         2'd2:    pos_sel = pos_ff[2];
         default: pos_sel = '0;
      endcase
   end

   // Configuration writes.
   always_comb begin
      alpha_in = alpha_ff;
      delta_in = delta_ff;
      if (csr_we) begin
         unique case (csr_index)
            tpts_pkg::CSR_ALPHA: alpha_in = csr_wdata;
            tpts_pkg::CSR_DELTA: delta_in = csr_wdata[11:0];
         endcase
      end
   end

   // Negation of the most negative value saturates.
   assign neg_y = (filt_ff[1] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -filt_ff[1];
   assign neg_z = (filt_ff[2] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -filt_ff[2];

   // Sequencer: drives the shared unit and steers its result into the
   // coordinate registers.
   always_comb begin
      state_in = state_ff;
      coord_in = coord_ff;
      phase_in = phase_ff;
      armed_in = armed_ff || new_target;
      pos_in   = pos_ff;
      xf_in    = xf_ff;
      filt_in  = filt_ff;
      mac_ctrl = '0;
      mac_op_a = tpts_pkg::OpaWidth'(pos_sel);
      mac_op_b = tpts_pkg::xf_coef(coord_ff, phase_ff);
      mac_init = tpts_pkg::AccWidth'(tpts_pkg::xf_offset(coord_ff)) <<< tpts_pkg::FracBits;
      rsp_load = 1'b0;

      unique case (state_ff)
         tpts_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser[0] == tpts_pkg::OP_POINT)) begin
               pos_in[0] = signed'(req_tdata[79:48]);
               pos_in[1] = signed'(req_tdata[111:80]);
               pos_in[2] = signed'(req_tdata[143:112]);
               coord_in  = 2'd0;
               phase_in  = 2'd0;
               state_in  = tpts_pkg::ST_XFORM;
            end
         end
         tpts_pkg::ST_XFORM: begin
            if (phase_ff == 2'd0) begin
               // Start a row: load the offset, first product; the previous
               // row's sum is complete and is rounded out here.
               mac_ctrl.acc_load = 1'b1;
               mac_ctrl.mul_en   = 1'b1;
               if (coord_ff != 2'd0) begin
                  xf_in[prev_coord] = mac_result;
               end
               phase_in = 2'd1;
            end else if (phase_ff != 2'd3) begin
               mac_ctrl.acc_add = 1'b1;
               mac_ctrl.mul_en  = 1'b1;
               phase_in         = phase_ff + 2'd1;
            end else begin
               mac_ctrl.acc_add = 1'b1;
               phase_in         = 2'd0;
               if (coord_ff == 2'd2) begin
                  state_in = tpts_pkg::ST_XLAST;
               end else begin
                  coord_in = coord_ff + 2'd1;
               end
            end
         end
         tpts_pkg::ST_XLAST: begin
            xf_in[2] = mac_result;
            coord_in = 2'd0;
            phase_in = 2'd0;
            if (armed_ff) begin
               // New target: the filter takes the transformed point as is.
               filt_in[0] = xf_ff[0];
               filt_in[1] = xf_ff[1];
               filt_in[2] = mac_result;
               armed_in   = 1'b0;
               state_in   = tpts_pkg::ST_DONE;
            end else begin
               state_in = tpts_pkg::ST_SMOOTH;
            end
         end
         tpts_pkg::ST_SMOOTH: begin
            // prev*2^16 + alpha*(new - prev), rounded, gives prev + step.
            mac_op_a = tpts_pkg::OpaWidth'(xf_ff[coord_ff]) -
                       tpts_pkg::OpaWidth'(filt_ff[coord_ff]);
            mac_op_b = signed'({2'b00, alpha_ff});
            mac_init = tpts_pkg::AccWidth'(filt_ff[coord_ff]) <<< tpts_pkg::FracBits;
            if (phase_ff == 2'd0) begin
               mac_ctrl.acc_load = 1'b1;
               mac_ctrl.mul_en   = 1'b1;
               if (coord_ff != 2'd0) begin
                  filt_in[prev_coord] = mac_result;
               end
               phase_in = 2'd1;
            end else begin
               mac_ctrl.acc_add = 1'b1;
               phase_in         = 2'd0;
               if (coord_ff == 2'd2) begin
                  state_in = tpts_pkg::ST_SLAST;
               end else begin
                  coord_in = coord_ff + 2'd1;
               end
            end
         end
         tpts_pkg::ST_SLAST: begin
            filt_in[2] = mac_result;
            state_in   = tpts_pkg::ST_DONE;
         end
         tpts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = tpts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_load ? {colour[7:0], colour[15:8], colour[23:16],
                                 neg_z, neg_y, filt_ff[0]}
                              : rsp_data_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpts_pkg::ST_IDLE;
         coord_ff     <= '0;
         phase_ff     <= '0;
         alpha_ff     <= 16'd13107;
         delta_ff     <= 12'd5;
         armed_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coord_ff     <= coord_in;
         phase_ff     <= phase_in;
         alpha_ff     <= alpha_in;
         delta_ff     <= delta_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The filter registers need no reset: an armed reload always fills them
   // before they are read.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      xf_ff       <= xf_in;
      filt_ff     <= filt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TPTS_ASSERT_NEXT(a_point_busy, req_accept && (req_tuser[0] == tpts_pkg::OP_POINT), !req_tready, "point beat did not start the sequencer")
   `TPTS_ASSERT_NEXT(a_pixel_quick, pix_en, req_tready, "pixel beat held the input side")
   `TPTS_ASSERT_SAME(a_coord_range, state_ff != tpts_pkg::ST_IDLE, coord_ff != 2'd3, "coordinate counter out of range")
   `TPTS_ASSERT_NEXT(a_arm_used, (state_ff == tpts_pkg::ST_XLAST) && armed_ff, !armed_ff && (state_ff == tpts_pkg::ST_DONE), "armed reload not consumed")
   `TPTS_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == tpts_pkg::ST_DONE, "result raised outside the done step")

endmodule

`default_nettype wire
